/* hdl/length_prefixed_crc16_frame_builder_unit_assert.svh */
// assertion macros used by the frame builder back end
`ifndef LENGTH_PREFIXED_CRC16_FRAME_BUILDER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_CRC16_FRAME_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define LPCF_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lpcf assertion failed");
// condition must never be true out of reset
`define LPCF_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lpcf forbidden condition seen");
`else
`define LPCF_ASSERT(name, clk, rstn, prop)
`define LPCF_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

/* hdl/lpcf_pkg.sv */
// shared types and constants of the frame builder
package lpcf_pkg;

  // field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned CntW    = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 4;

  // defaults for top level parameters
  localparam int unsigned MaxPayloadWordsDef = 16;
  localparam int unsigned CmdDepthDef        = 2;

  // item opcodes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROTOCOL_ID      = 4'd0,
    REG_PROTOCOL_VERSION = 4'd1
  } reg_e;

  // classified command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_ERROR   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [WordW-1:0]  data;   // msg id on start opcode, payload word on payload opcode
    logic [CntW-1:0]   count;  // saturated payload word count on start
    logic              last;   // crc follows this command
  } lpcf_cmd_t;

endpackage

/* hdl/lpcf_if.sv */
// handshake channel interfaces of the frame builder
interface lpcf_item_if import lpcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [WordW-1:0] msg_id;
  logic [CntW-1:0]  payload_count;
  logic [WordW-1:0] payload_word;

  modport source (output valid, opcode, msg_id, payload_count, payload_word, input ready);
  modport sink   (input valid, opcode, msg_id, payload_count, payload_word, output ready);
endinterface

interface lpcf_result_if import lpcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             frame_end;
  logic             seq_error;

  modport source (output valid, frame_byte, frame_end, seq_error, input ready);
  modport sink   (input valid, frame_byte, frame_end, seq_error, output ready);
endinterface

interface lpcf_cfg_if import lpcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/lpcf_front.sv */
// front end: accepts items, tracks frame sequencing, classifies into commands
module lpcf_front import lpcf_pkg::*; #(
  parameter int unsigned MaxPayloadWords = MaxPayloadWordsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lpcf_item_if.sink        item_i,
  input  logic             full_i,
  output logic             push_o,
  output lpcf_cmd_t        cmd_o
);

  logic            frame_open_q, frame_open_d;
  logic [CntW-1:0] words_left_q, words_left_d;
  logic [CntW-1:0] cnt_sat;
  logic [CntW-1:0] left_dec;

  // accept whenever the command queue has room
  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  // clamp requested payload length
  assign cnt_sat  = (int'(item_i.payload_count) > MaxPayloadWords) ?
                    CntW'(MaxPayloadWords) : item_i.payload_count;
  assign left_dec = (words_left_q != '0) ? words_left_q - 1'b1 : '0;

  // classify item and compute next sequencing state
  always_comb begin
    frame_open_d = frame_open_q;
    words_left_d = words_left_q;
    cmd_o.kind   = CMD_ERROR;
    cmd_o.data   = item_i.msg_id;
    cmd_o.count  = cnt_sat;
    cmd_o.last   = 1'b0;
    if (item_i.opcode == OP_START) begin
      if (!frame_open_q) begin
        cmd_o.kind   = CMD_START;
        cmd_o.last   = (cnt_sat == '0);
        frame_open_d = (cnt_sat != '0);
        words_left_d = cnt_sat;
      end
    end else begin
      cmd_o.data = item_i.payload_word;
      if (frame_open_q) begin
        cmd_o.kind   = CMD_PAYLOAD;
        cmd_o.last   = (left_dec == '0);
        frame_open_d = (left_dec != '0);
        words_left_d = left_dec;
      end
    end
  end

  // sequencing state, updated per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      words_left_q <= '0;
    end else if (push_o) begin
      frame_open_q <= frame_open_d;
      words_left_q <= words_left_d;
    end
  end

endmodule

/* hdl/lpcf_fifo.sv */
// short command queue between front and back
module lpcf_fifo import lpcf_pkg::*; #(
  parameter int unsigned Depth = CmdDepthDef  // 2 or more
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lpcf_cmd_t wdata_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output lpcf_cmd_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntFW = $clog2(Depth + 1);

  lpcf_cmd_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntFW-1:0] count_q;

  assign full_o  = (count_q == CntFW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/lpcf_back.sv */
// back end: serializes commands into frame bytes and appends the crc
`include "length_prefixed_crc16_frame_builder_unit_assert.svh"
module lpcf_back import lpcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpcf_cfg_if.sink    cfg_i,
  input  logic        cmd_valid_i,
  input  lpcf_cmd_t   cmd_i,
  output logic        pop_o,
  lpcf_result_if.source result_o
);

  localparam int unsigned IdxW      = 5;
  localparam logic [IdxW-1:0] HdrBytes = 5'd16;
  localparam logic [IdxW-1:0] PldBytes = 5'd4;
  localparam logic [IdxW-1:0] IdxLast  = 5'd17;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [WordW-1:0] LenBase = 32'd18;
  localparam logic [WordW-1:0] PidReset = 32'h0000_000C;
  localparam logic [WordW-1:0] VerReset = 32'h0000_000A;

  // msb-first crc-16 update over one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [ByteW-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  logic [WordW-1:0] pid_q, ver_q;
  logic [15:0]      crc_q, crc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q;
  logic [ByteW-1:0] frame_byte_q, byte_d;
  logic             frame_end_q, end_d;
  logic             seq_error_q, err_d;
  logic             adv;
  logic             final_byte;
  logic             crc_lo;
  logic [IdxW-1:0]  data_bytes;
  logic [WordW-1:0] len_word;
  logic [WordW-1:0] cur_word;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= PidReset;
      ver_q <= VerReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PROTOCOL_ID:      pid_q <= cfg_i.data;
        REG_PROTOCOL_VERSION: ver_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // step forward when a command waits and the output slot frees up
  assign adv   = cmd_valid_i && (!out_valid_q || result_o.ready);
  assign pop_o = adv && final_byte;

  assign len_word   = LenBase + {{(WordW - CntW - 2){1'b0}}, cmd_i.count, 2'b00};
  assign data_bytes = (cmd_i.kind == CMD_START) ? HdrBytes : PldBytes;

  // header word select
  always_comb begin
    cur_word = cmd_i.data;
    if (cmd_i.kind == CMD_START) begin
      case (idx_q[3:2])
        2'd0:    cur_word = len_word;
        2'd1:    cur_word = pid_q;
        2'd2:    cur_word = ver_q;
        default: cur_word = cmd_i.data;
      endcase
    end
  end

  // byte generation and crc tracking
  always_comb begin
    byte_d     = '0;
    end_d      = 1'b0;
    err_d      = 1'b0;
    final_byte = 1'b0;
    crc_lo     = 1'b0;
    crc_d      = crc_q;
    if (cmd_i.kind == CMD_ERROR) begin
      end_d      = 1'b1;
      err_d      = 1'b1;
      final_byte = 1'b1;
    end else if (idx_q < data_bytes) begin
      case (idx_q[1:0])
        2'd0:    byte_d = cur_word[31:24];
        2'd1:    byte_d = cur_word[23:16];
        2'd2:    byte_d = cur_word[15:8];
        default: byte_d = cur_word[7:0];
      endcase
      crc_d      = crc_step(crc_q, byte_d);
      final_byte = (idx_q == data_bytes - 1'b1) && !cmd_i.last;
    end else if (idx_q == data_bytes) begin
      byte_d = crc_q[15:8];
    end else begin
      byte_d     = crc_q[7:0];
      end_d      = 1'b1;
      final_byte = 1'b1;
      crc_lo     = 1'b1;
      crc_d      = CrcInit;
    end
    idx_d = final_byte ? '0 : idx_q + 1'b1;
  end

  // sequencer state and running crc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      crc_q <= CrcInit;
    end else if (adv) begin
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frame_byte_q <= byte_d;
      frame_end_q  <= end_d;
      seq_error_q  <= err_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.frame_byte = frame_byte_q;
  assign result_o.frame_end  = frame_end_q;
  assign result_o.seq_error  = seq_error_q;

  // checks
  `LPCF_ASSERT(a_err_ends_frame, clk_i, rst_ni, out_valid_q && seq_error_q |-> frame_end_q)
  `LPCF_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, idx_q > IdxLast)
  `LPCF_ASSERT(a_err_at_idx0, clk_i, rst_ni, cmd_valid_i && cmd_i.kind == CMD_ERROR |-> idx_q == '0)
  `LPCF_ASSERT(a_crc_restart, clk_i, rst_ni, adv && crc_lo |=> crc_q == CrcInit)

endmodule

/* hdl/length_prefixed_crc16_frame_builder_unit.sv */
// top level: front classifier, command queue and byte serializer with crc-16
// path: an item's command passes through the command queue, then the output byte register
// throughput: one frame byte per cycle while the sink is ready; bytes per command:
//   start 16 bytes (18 with zero count), payload word 4 (6 when last), error 1
// reset: async active low; clears queue and sequencing, crc to 0xFFFF, ids to 12/10
module length_prefixed_crc16_frame_builder_unit import lpcf_pkg::*; #(
  parameter int unsigned MaxPayloadWords = MaxPayloadWordsDef,
  parameter int unsigned CmdDepth        = CmdDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lpcf_item_if.sink     item_i,
  lpcf_cfg_if.sink      cfg_i,
  lpcf_result_if.source result_o
);

  lpcf_cmd_t push_cmd, head_cmd;
  logic      push, pop, full, head_valid;

  // item classification
  lpcf_front #(
    .MaxPayloadWords(MaxPayloadWords)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // command queue
  lpcf_fifo #(
    .Depth(CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .rdata_o (head_cmd)
  );

  // byte serializer
  lpcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .result_o    (result_o)
  );

endmodule
